FILE: rtl/ctbw_pkg.sv
`timescale 1ns / 1ps
package ctbw_pkg;

  localparam int TARGET_BITS = 256;
  localparam int WORK_BITS   = 128;
  localparam int HALF_BITS   = 64;
  localparam int MANT_BITS   = 24;
  localparam logic [7:0] EXP_BIAS = 8'd3;
  localparam logic [7:0] EXP_MAX  = 8'd32;

  // one word in flight through the division chain
  typedef struct packed {
    logic [31:0]            cbits;
    logic [TARGET_BITS-1:0] den;
    logic [TARGET_BITS-1:0] rem;
    logic [WORK_BITS-1:0]   quo;
    logic                   zero;
  } div_word_t;

  // exponent gives a non-zero placement of the mantissa
  function automatic logic exp_ok(input logic [7:0] e);
    return (e >= EXP_BIAS) && (e <= EXP_MAX);
  endfunction

  // byte offset of the mantissa, valid only when exp_ok
  function automatic logic [4:0] exp_off(input logic [7:0] e);
    logic [7:0] d;
    d = e - EXP_BIAS;
    return d[4:0];
  endfunction

endpackage

FILE: rtl/compact_target_block_work_unit.sv
`timescale 1ns / 1ps
// channel   | valid         | ready         | fields
// compact   | compact_valid | compact_ready | compact_bits
// work      | work_valid    | work_ready    | work_low, work_high
//
// one word enters per cycle while the output is not stalled; the stages are the expand stage,
// 256 restoring division stages, one per numerator bit, and the output stage
// reset clears the valid bits of every stage; payload registers are not reset
// a stalled output freezes the whole chain, so words are neither lost nor repeated
module compact_target_block_work_unit import ctbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 compact_valid,
  output logic                 compact_ready,
  input  logic [31:0]          compact_bits,
  output logic                 work_valid,
  input  logic                 work_ready,
  output logic [HALF_BITS-1:0] work_low,
  output logic [HALF_BITS-1:0] work_high
);

  logic      en;
  logic      stage_v [0:TARGET_BITS];
  div_word_t stage_d [0:TARGET_BITS];

  // chain advances whenever the output register is free or being taken
  assign en            = !work_valid || work_ready;
  assign compact_ready = en;

  ctbw_expand u_expand (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_v         (compact_valid),
    .compact_bits (compact_bits),
    .out_v        (stage_v[0]),
    .out_d        (stage_d[0])
  );

  // division chain, most significant quotient bit first
  for (genvar i = 0; i < TARGET_BITS; i++) begin : g_step
    ctbw_div_step #(
      .BIT (TARGET_BITS - 1 - i)
    ) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .in_v  (stage_v[i]),
      .in_d  (stage_d[i]),
      .out_v (stage_v[i+1]),
      .out_d (stage_d[i+1])
    );
  end

  ctbw_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_v      (stage_v[TARGET_BITS]),
    .in_d      (stage_d[TARGET_BITS]),
    .out_v     (work_valid),
    .work_low  (work_low),
    .work_high (work_high)
  );

  // checks
  a_rst_clear: assert property (@(posedge clk) rst |=> !work_valid && !stage_v[0])
    else $error("valid bits not cleared by reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (compact_valid && compact_ready) |=> stage_v[0])
    else $error("accepted word missing from first stage");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage_v[TARGET_BITS]) && $stable(stage_d[TARGET_BITS].quo))
    else $error("chain moved during stall");

endmodule

FILE: rtl/ctbw_expand.sv
`timescale 1ns / 1ps
module ctbw_expand import ctbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_v,
  input  logic [31:0] compact_bits,
  output logic        out_v,
  output div_word_t   out_d
);

  logic [7:0]             e;
  logic [MANT_BITS-1:0]   m;
  logic [7:0]             sh;
  logic [TARGET_BITS-1:0] t;
  div_word_t              d_next;

  // expand the compact word to the target and form the divisor
  always_comb begin
    e  = compact_bits[31:24];
    m  = compact_bits[MANT_BITS-1:0];
    sh = {exp_off(e), 3'b000};
    t  = exp_ok(e) ? ({{(TARGET_BITS-MANT_BITS){1'b0}}, m} << sh) : '0;
    d_next.cbits = compact_bits;
    d_next.den   = t + TARGET_BITS'(1);
    d_next.rem   = '0;
    d_next.quo   = '0;
    d_next.zero  = !exp_ok(e) || (m == '0);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule

FILE: rtl/ctbw_div_step.sv
`timescale 1ns / 1ps
module ctbw_div_step import ctbw_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_v,
  input  div_word_t in_d,
  output logic      out_v,
  output div_word_t out_d
);

  localparam logic [8:0] BPOS = 9'(BIT);

  logic [8:0]             sh9;
  logic [8:0]             pos9;
  logic                   hit;
  logic                   nbit;
  logic [TARGET_BITS-1:0] shifted;
  logic [TARGET_BITS+1:0] diff;
  logic                   take;
  div_word_t              d_next;

  // numerator bit: inverse of target bit at this position
  always_comb begin
    sh9  = {1'b0, exp_off(in_d.cbits[31:24]), 3'b000};
    pos9 = BPOS - sh9;
    hit  = exp_ok(in_d.cbits[31:24]) && (BPOS >= sh9) && (pos9 < 9'(MANT_BITS));
    nbit = !(hit && in_d.cbits[pos9[4:0]]);
  end

  // one restoring step: shift in, trial subtract, keep or restore
  always_comb begin
    shifted = {in_d.rem[TARGET_BITS-2:0], nbit};
    diff    = {1'b0, in_d.rem[TARGET_BITS-1], shifted} - {2'b00, in_d.den};
    take    = !diff[TARGET_BITS+1];
    d_next  = in_d;
    d_next.rem = take ? diff[TARGET_BITS-1:0] : shifted;
    if (BIT < WORK_BITS) begin
      d_next.quo[BIT % WORK_BITS] = take;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule

FILE: rtl/ctbw_finish.sv
`timescale 1ns / 1ps
module ctbw_finish import ctbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  div_word_t            in_d,
  output logic                 out_v,
  output logic [HALF_BITS-1:0] work_low,
  output logic [HALF_BITS-1:0] work_high
);

  logic [WORK_BITS-1:0] sum;

  // final increment, wrapping in the kept width
  always_comb begin
    sum = in_d.zero ? '0 : (in_d.quo + WORK_BITS'(1));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_low  <= sum[HALF_BITS-1:0];
      work_high <= sum[WORK_BITS-1:HALF_BITS];
    end
  end

endmodule

FILE: bench/tb_compact_target_block_work_unit.sv
`timescale 1ns / 1ps
module tb_compact_target_block_work_unit;
  import ctbw_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 compact_valid;
  logic                 compact_ready;
  logic [31:0]          compact_bits;
  logic                 work_valid;
  logic                 work_ready;
  logic [HALF_BITS-1:0] work_low;
  logic [HALF_BITS-1:0] work_high;

  // expected block work, oldest first
  logic [WORK_BITS-1:0] work_expected_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req_count;
  int hold_len;
  int mismatch_count;
  int words_sent;
  int words_checked;

  compact_target_block_work_unit u_top (
    .clk(clk),
    .rst(rst),
    .compact_valid(compact_valid),
    .compact_ready(compact_ready),
    .compact_bits(compact_bits),
    .work_valid(work_valid),
    .work_ready(work_ready),
    .work_low(work_low),
    .work_high(work_high)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // work = 2^256 / (target + 1), low 128 bits kept
  function automatic logic [WORK_BITS-1:0] expected_work(input logic [31:0] w);
    logic [7:0]             e;
    logic [TARGET_BITS-1:0] target;
    logic [TARGET_BITS-1:0] quot;
    e = w[31:24];
    target = '0;
    if (e >= EXP_BIAS && e <= EXP_MAX)
      target = {{(TARGET_BITS-MANT_BITS){1'b0}}, w[MANT_BITS-1:0]} << (8 * (e - EXP_BIAS));
    if (target == '0) return '0;
    quot = (~target) / (target + 1'b1);
    return quot[WORK_BITS-1:0] + 1'b1;
  endfunction

  // send one word, idling beforehand at random
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      compact_valid <= 1'b0;
      @(posedge clk);
    end
    compact_valid <= 1'b1;
    compact_bits  <= w;
    @(posedge clk);
    while (!compact_ready) @(posedge clk);
    work_expected_q.push_back(expected_work(w));
    words_sent++;
  endtask

  task automatic end_send();
    compact_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (work_expected_q.size() != 0) @(posedge clk);
  endtask

  // receiver ready, with a long hold-off on request
  initial begin : recv_proc
    int hold_done;
    int hold_left;
    hold_done = 0;
    hold_left = 0;
    work_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_count != hold_done) begin
        hold_done = hold_req_count;
        hold_left = hold_len;
      end
      if (rst) begin
        work_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        work_ready <= 1'b0;
      end else begin
        work_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    logic [WORK_BITS-1:0] exp_work;
    if (!rst && work_valid && work_ready) begin
      if (work_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected work word low=%h high=%h", work_low, work_high);
      end else begin
        exp_work = work_expected_q.pop_front();
        words_checked++;
        if (work_low !== exp_work[63:0] || work_high !== exp_work[127:64]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("work mismatch: expected high=%h low=%h, got high=%h low=%h",
                     exp_work[127:64], exp_work[63:0], work_high, work_low);
        end
      end
    end
  end

  // extremes of exponent and mantissa
  task automatic test_directed();
    logic [31:0] words[$];
    words = '{32'h00000000, 32'hffffffff, 32'h00ffffff, 32'h01ffffff, 32'h02ffffff,
              32'h03000001, 32'h03ffffff, 32'h03000000, 32'h20ffffff, 32'h20000001,
              32'h21ffffff, 32'hff000001, 32'h1d00ffff, 32'h207fffff, 32'h20800000,
              32'h04000001, 32'h1f123456, 32'h10000000, 32'h05800000, 32'h1c00ffff};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (words[i]) send_word(words[i]);
    end_send();
    wait_drained();
  endtask

  function automatic logic [31:0] random_compact();
    logic [7:0]  e;
    logic [23:0] m;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 70) e = 8'($urandom_range(3, 32));
    else e = 8'($urandom);
    m = 24'($urandom);
    if ($urandom_range(9) == 0) m = 24'($urandom_range(3));
    else if ($urandom_range(9) == 0) m = 24'hffffff;
    return {e, m};
  endfunction

  task automatic test_random(input int n, input int sp, input int rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    repeat (n) send_word(random_compact());
    end_send();
    wait_drained();
  endtask

  // receiver stops for a long stretch so the chain fills and stalls the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 700;
    hold_req_count++;
    repeat (400) send_word(random_compact());
    end_send();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    compact_valid <= 1'b0;
    compact_bits <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req_count = 0;
    hold_len = 0;
    mismatch_count = 0;
    words_sent = 0;
    words_checked = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 21, 80);
    test_random(500, 80, 21);
    test_random(550, 0, 0);
    test_backpressure();
    repeat (300) @(posedge clk);
    $display("covered %0d compact words (%0d checked): exponent edges, zero targets,",
             words_sent, words_checked);
    $display("random idling on both channels and a long output stall");
    if (mismatch_count == 0 && work_expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
